### rtl/dense_matvec_engine_assert.svh
// Assertion macros for the dense matrix-vector engine.
`ifndef DENSE_MATVEC_ENGINE_ASSERT_SVH
`define DENSE_MATVEC_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DMV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dmv_pkg.sv
// Shared constants and types for the dense matrix-vector engine.
package dmv_pkg;

  localparam int MAX_DIM_DEF = 32;

  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int FIDX_W  = 5;
  localparam int NUSED_W = 6;

  localparam logic [NUSED_W-1:0] NUSED_RST = 6'd32;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_VECTOR = 1'b1
  } action_t;

endpackage

### rtl/dmv_ram.sv
// Generic simple dual-port RAM with registered read.
module dmv_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dmv_mac.sv
// Multiply-accumulate datapath: registered product, round, saturating add.
module dmv_mac (
  input  logic         clk,
  input  dmv_pkg::val_t coef,
  input  dmv_pkg::val_t x,
  input  dmv_pkg::acc_t acc,
  output dmv_pkg::acc_t sum
);

  dmv_pkg::acc_t          prod;
  dmv_pkg::acc_t          q;
  logic [dmv_pkg::ACC_W:0] wide;

  always_ff @(posedge clk) begin
    prod <= dmv_pkg::acc_t'(coef) * dmv_pkg::acc_t'(x);
  end

  always_comb begin
    // round half up to Q16.16
    q    = (prod + dmv_pkg::acc_t'(32768)) >>> 16;
    wide = {acc[dmv_pkg::ACC_W-1], acc} + {q[dmv_pkg::ACC_W-1], q};
    if (wide[dmv_pkg::ACC_W] != wide[dmv_pkg::ACC_W-1]) begin
      sum = wide[dmv_pkg::ACC_W] ? {1'b1, {(dmv_pkg::ACC_W-1){1'b0}}}
                                 : {1'b0, {(dmv_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum = wide[dmv_pkg::ACC_W-1:0];
    end
  end

endmodule

### rtl/dense_matvec_engine.sv
// Dense matrix-vector engine: top level with control, coefficient and accumulator RAMs.
// Coefficient load: accepted back to back while idle. Vector element: one row per cycle
//   through the accumulator read-modify-write pipeline plus drain; index >= n is skipped.
// Last element: then OUT_RD, OUT_WAIT, OUT_SEND for each of n result rows, waiting on m_axis_tready.
// rst (synchronous) clears control, sets n_used to 32 and zeroes all accumulators at once
//   through per-row valid bits; coefficients are undefined until written.
module dense_matvec_engine #(
  parameter int MAX_DIM = dmv_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dmv_pkg::NUSED_W-1:0]    cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // mat_row[4:0], mat_col[9:5], mat_value[41:10], vec_index[46:42],
  // vec_value[78:47], zero[79]
  input  logic [dmv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  // vec_last
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_index[4:0], out_value[36:5], zero[39:37]
  output logic [dmv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // out_last
  output logic                           m_axis_tlast
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CAW    = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int CMP_W  = 7;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MAC      = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_OUT_RD   = 6'b001000,
    ST_OUT_WAIT = 6'b010000,
    ST_OUT_SEND = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [dmv_pkg::NUSED_W-1:0] n_used;
  logic [CNT_W-1:0]            n_eff;

  logic [dmv_pkg::FIDX_W-1:0]  in_row, in_col, in_vidx;
  dmv_pkg::val_t               in_mval, in_vval;
  logic                        accept;

  dmv_pkg::val_t               vec_x;
  logic [dmv_pkg::FIDX_W-1:0]  vec_j;
  logic                        vec_last;

  logic [IDX_W-1:0]            row;
  logic                        row_end;
  logic                        s1_v, s2_v;
  logic [IDX_W-1:0]            s1_row, s2_row;

  logic                        coef_we;
  logic [CAW-1:0]              coef_waddr, coef_raddr;
  dmv_pkg::val_t               coef_rdata;

  logic [MAX_DIM-1:0]          acc_vld;
  logic                        vld_q;
  logic [IDX_W-1:0]            acc_raddr;
  dmv_pkg::acc_t               acc_rdata, acc_cur, acc_sum;

  dmv_pkg::val_t               out_val;
  logic [dmv_pkg::FIDX_W-1:0]  out_idx;

  assign in_row  = s_axis_tdata[4:0];
  assign in_col  = s_axis_tdata[9:5];
  assign in_mval = s_axis_tdata[41:10];
  assign in_vidx = s_axis_tdata[46:42];
  assign in_vval = s_axis_tdata[78:47];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (n_used == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(n_used) > CMP_W'(MAX_DIM)) begin
      n_eff = CNT_W'(MAX_DIM);
    end else begin
      n_eff = CNT_W'(n_used);
    end
  end

  assign row_end = (CMP_W'(row) == CMP_W'(n_eff) - CMP_W'(1));

  // coefficient store
  assign coef_we    = accept && (s_axis_tuser == dmv_pkg::ACT_LOAD) &&
                      (CMP_W'(in_row) < CMP_W'(n_eff)) && (CMP_W'(in_col) < CMP_W'(n_eff));
  assign coef_waddr = CAW'(int'(in_row) * MAX_DIM + int'(in_col));
  assign coef_raddr = CAW'(int'(row) * MAX_DIM + int'(vec_j));

  dmv_ram #(
    .WIDTH (dmv_pkg::VAL_W),
    .DEPTH (MAX_DIM * MAX_DIM),
    .ADDR_W(CAW)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(in_mval),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  // accumulator store
  assign acc_raddr = (state == ST_OUT_RD) ? row : s1_row;
  assign acc_cur   = vld_q ? acc_rdata : '0;

  dmv_ram #(
    .WIDTH (dmv_pkg::ACC_W),
    .DEPTH (MAX_DIM),
    .ADDR_W(IDX_W)
  ) u_acc_ram (
    .clk  (clk),
    .we   (s2_v),
    .waddr(s2_row),
    .wdata(acc_sum),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  dmv_mac u_mac (
    .clk (clk),
    .coef(coef_rdata),
    .x   (vec_x),
    .acc (acc_cur),
    .sum (acc_sum)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == dmv_pkg::ACT_VECTOR)) begin
          if (CMP_W'(in_vidx) < CMP_W'(n_eff)) begin
            state_next = ST_MAC;
          end else if (s_axis_tlast) begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_MAC: begin
        if (row_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = vec_last ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_OUT_RD:   state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: state_next = ST_OUT_SEND;
      ST_OUT_SEND: begin
        if (m_axis_tready) begin
          state_next = m_axis_tlast ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      n_used        <= dmv_pkg::NUSED_RST;
      acc_vld       <= '0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      row           <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        n_used <= cfg_wdata;
      end
      s1_v <= (state == ST_MAC);
      s2_v <= s1_v;
      if (s2_v) begin
        acc_vld[s2_row] <= 1'b1;
      end
      case (state)
        ST_IDLE: row <= '0;
        ST_MAC: begin
          if (!row_end) begin
            row <= row + IDX_W'(1);
          end else begin
            row <= '0;
          end
        end
        ST_OUT_WAIT: m_axis_tvalid <= 1'b1;
        ST_OUT_SEND: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            row           <= row + IDX_W'(1);
            if (m_axis_tlast) begin
              acc_vld <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_row <= row;
    s2_row <= s1_row;
    vld_q  <= acc_vld[acc_raddr];
    if (accept && (s_axis_tuser == dmv_pkg::ACT_VECTOR)) begin
      vec_x    <= in_vval;
      vec_j    <= in_vidx;
      vec_last <= s_axis_tlast;
    end
    if (state == ST_OUT_WAIT) begin
      out_idx      <= dmv_pkg::FIDX_W'(row);
      m_axis_tlast <= row_end;
      if (acc_cur > dmv_pkg::acc_t'(32'sh7fffffff)) begin
        out_val <= 32'sh7fffffff;
      end else if (acc_cur < -dmv_pkg::acc_t'(64'sd2147483648)) begin
        out_val <= 32'sh80000000;
      end else begin
        out_val <= acc_cur[dmv_pkg::VAL_W-1:0];
      end
    end
  end

  assign m_axis_tdata = {3'b000, out_val, out_idx};

  `include "dense_matvec_engine_assert.svh"

  `DMV_ASSERT_NOW(a_no_in_while_out, clk, rst, s_axis_tready, !m_axis_tvalid,
    "item accepted while a result is pending")
  `DMV_ASSERT_NOW(a_rmw_rows_differ, clk, rst, s1_v && s2_v, s1_row != s2_row,
    "accumulator read and write hit the same row")
  `DMV_ASSERT_NEXT(a_clear_after_last, clk, rst,
    m_axis_tvalid && m_axis_tready && m_axis_tlast, acc_vld == '0,
    "accumulators not cleared after last result")

endmodule
